### hdl/knn_radius_topk_select_macros.svh
// assertion macros shared by the knn selection modules
`ifndef KNN_RADIUS_TOPK_SELECT_MACROS_SVH
`define KNN_RADIUS_TOPK_SELECT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define KNN_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen outside reset
`define KNN_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

### hdl/knnsel_pkg.sv
// types, constants and helpers for the knn radius top-k selector
package knnsel_pkg;

	localparam int MAX_NEIGHBORS  = 64;
	localparam int COORD_BITS     = 20;
	localparam int INDEX_BITS     = 24;

	localparam int DIST_BITS      = 42;
	localparam int OUT_INDEX_BITS = 25;
	localparam int RANK_BITS      = 6;
	localparam int NC_BITS        = 7;
	localparam int CNT_BITS       = $clog2(MAX_NEIGHBORS + 1);
	localparam int KW_BITS        = (NC_BITS > CNT_BITS) ? NC_BITS : CNT_BITS;

	localparam int DIFF_BITS      = COORD_BITS + 1;
	localparam int ABS_BITS       = DIFF_BITS;
	localparam int SQ_BITS        = 2 * ABS_BITS;
	localparam int SUM_BITS       = SQ_BITS + 2;

	localparam int QUEUE_DEPTH    = 8;
	localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

	localparam int CFG_IDX_BITS   = 1;
	localparam int CFG_DATA_BITS  = DIST_BITS;

	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
	localparam logic [NC_BITS-1:0] NEIGHBOR_COUNT_RESET = NC_BITS'(1);
	localparam logic [DIST_BITS-1:0] MAX_SQ_DISTANCE_RESET = DIST_BITS'(64'd3298534883328);

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_NEIGHBOR_COUNT  = 1'b0,
		CFG_MAX_SQ_DISTANCE = 1'b1
	} cfg_reg_t;

	// back end states
	typedef enum logic {
		BK_INSERT,
		BK_EMIT
	} back_state_t;

	// live configuration as seen by the back end
	typedef struct packed {
		logic [CNT_BITS-1:0]  k;
		logic [DIST_BITS-1:0] maxd;
	} cfg_t;

	// classified candidate travelling through the queue
	typedef struct packed {
		logic [DIST_BITS-1:0]  sq_dist;
		logic [INDEX_BITS-1:0] idx;
		logic                  first;
		logic                  last;
	} cand_t;

	// one slot of the sorted list
	typedef struct packed {
		logic [DIST_BITS-1:0]  sq_dist;
		logic [INDEX_BITS-1:0] idx;
		logic                  valid;
	} slot_t;

	// magnitude of a coordinate difference
	function automatic logic [ABS_BITS-1:0] abs_diff(input logic signed [DIFF_BITS-1:0] d);
		logic signed [DIFF_BITS-1:0] n;
		n = -d;
		return d[DIFF_BITS-1] ? ABS_BITS'(n) : ABS_BITS'(d);
	endfunction

endpackage

### hdl/knnsel_ifs.sv
// request channels: candidate points in, neighbours out
interface knnsel_point_if;
	logic                                        valid;
	logic                                        ready;
	logic signed [knnsel_pkg::COORD_BITS-1:0]    query_x;
	logic signed [knnsel_pkg::COORD_BITS-1:0]    query_y;
	logic signed [knnsel_pkg::COORD_BITS-1:0]    query_z;
	logic signed [knnsel_pkg::COORD_BITS-1:0]    point_x;
	logic signed [knnsel_pkg::COORD_BITS-1:0]    point_y;
	logic signed [knnsel_pkg::COORD_BITS-1:0]    point_z;
	logic        [knnsel_pkg::INDEX_BITS-1:0]    point_index;
	logic                                        first_point;
	logic                                        last_point;

	modport source (output valid, query_x, query_y, query_z, point_x, point_y, point_z,
		point_index, first_point, last_point, input ready);
	modport sink (input valid, query_x, query_y, query_z, point_x, point_y, point_z,
		point_index, first_point, last_point, output ready);
endinterface

interface knnsel_nbr_if;
	logic                                          valid;
	logic                                          ready;
	logic        [knnsel_pkg::RANK_BITS-1:0]       neighbor_rank;
	logic signed [knnsel_pkg::OUT_INDEX_BITS-1:0]  neighbor_index;
	logic        [knnsel_pkg::DIST_BITS-1:0]       neighbor_sq_distance;
	logic                                          last_neighbor;

	modport source (output valid, neighbor_rank, neighbor_index, neighbor_sq_distance,
		last_neighbor, input ready);
	modport sink (input valid, neighbor_rank, neighbor_index, neighbor_sq_distance,
		last_neighbor, output ready);
endinterface

### hdl/knnsel_front.sv
// front end: accepts candidates and computes the squared distance in three stages
module knnsel_front (
	input  logic                            clk,
	input  logic                            arst_n,
	knnsel_point_if.sink                    pts,
	input  logic [knnsel_pkg::QCNT_BITS-1:0] q_count,
	output logic                            push,
	output knnsel_pkg::cand_t               push_data
);

	localparam int TW = knnsel_pkg::QCNT_BITS + 1;

	logic accept;
	logic [TW-1:0] in_use;

	logic v_s1, v_s2, v_s3;
	logic signed [knnsel_pkg::DIFF_BITS-1:0] dx_s1, dy_s1, dz_s1;
	logic [knnsel_pkg::INDEX_BITS-1:0] idx_s1, idx_s2;
	logic first_s1, last_s1, first_s2, last_s2;
	logic [knnsel_pkg::SQ_BITS-1:0] sx_s2, sy_s2, sz_s2;
	knnsel_pkg::cand_t cand_s3;

	logic signed [knnsel_pkg::DIFF_BITS-1:0] dx, dy, dz;
	logic [knnsel_pkg::ABS_BITS-1:0] ax, ay, az;
	logic [knnsel_pkg::SUM_BITS-1:0] sum;

	// credit: queue entries plus items in flight must never exceed the queue depth
	assign in_use = TW'(q_count) + TW'(v_s1) + TW'(v_s2) + TW'(v_s3);
	assign pts.ready = in_use < TW'(knnsel_pkg::QUEUE_DEPTH);
	assign accept = pts.valid & pts.ready;

	// coordinate differences
	assign dx = knnsel_pkg::DIFF_BITS'(pts.query_x) - knnsel_pkg::DIFF_BITS'(pts.point_x);
	assign dy = knnsel_pkg::DIFF_BITS'(pts.query_y) - knnsel_pkg::DIFF_BITS'(pts.point_y);
	assign dz = knnsel_pkg::DIFF_BITS'(pts.query_z) - knnsel_pkg::DIFF_BITS'(pts.point_z);

	// magnitudes for squaring
	assign ax = knnsel_pkg::abs_diff(dx_s1);
	assign ay = knnsel_pkg::abs_diff(dy_s1);
	assign az = knnsel_pkg::abs_diff(dz_s1);

	// sum of squares, saturated at the distance ceiling
	assign sum = knnsel_pkg::SUM_BITS'(sx_s2) + knnsel_pkg::SUM_BITS'(sy_s2)
		+ knnsel_pkg::SUM_BITS'(sz_s2);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		dx_s1    <= dx;
		dy_s1    <= dy;
		dz_s1    <= dz;
		idx_s1   <= pts.point_index;
		first_s1 <= pts.first_point;
		last_s1  <= pts.last_point;

		sx_s2    <= knnsel_pkg::SQ_BITS'(ax) * knnsel_pkg::SQ_BITS'(ax);
		sy_s2    <= knnsel_pkg::SQ_BITS'(ay) * knnsel_pkg::SQ_BITS'(ay);
		sz_s2    <= knnsel_pkg::SQ_BITS'(az) * knnsel_pkg::SQ_BITS'(az);
		idx_s2   <= idx_s1;
		first_s2 <= first_s1;
		last_s2  <= last_s1;

		cand_s3.sq_dist <= (sum > knnsel_pkg::SUM_BITS'(knnsel_pkg::DIST_MAX))
			? knnsel_pkg::DIST_MAX : sum[knnsel_pkg::DIST_BITS-1:0];
		cand_s3.idx     <= idx_s2;
		cand_s3.first   <= first_s2;
		cand_s3.last    <= last_s2;
	end

	assign push = v_s3;
	assign push_data = cand_s3;

endmodule

### hdl/knnsel_fifo.sv
// short queue of classified candidates between front and back
module knnsel_fifo (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	input  knnsel_pkg::cand_t                push_data,
	input  logic                             pop,
	output knnsel_pkg::cand_t                pop_data,
	output logic                             not_empty,
	output logic [knnsel_pkg::QCNT_BITS-1:0] count
);

	`include "knn_radius_topk_select_macros.svh"

	knnsel_pkg::cand_t mem_q [knnsel_pkg::QUEUE_DEPTH];
	logic [knnsel_pkg::QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [knnsel_pkg::QCNT_BITS-1:0] count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + knnsel_pkg::QPTR_BITS'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + knnsel_pkg::QPTR_BITS'(1);
			if (push && !pop)
				count_q <= count_q + knnsel_pkg::QCNT_BITS'(1);
			else if (pop && !push)
				count_q <= count_q - knnsel_pkg::QCNT_BITS'(1);
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	assign pop_data  = mem_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

	`KNN_ASSERT(a_fifo_no_overflow, push |-> (count_q != knnsel_pkg::QCNT_BITS'(knnsel_pkg::QUEUE_DEPTH)) || pop, "request pushed into a full queue")
	`KNN_NEVER(a_fifo_no_underflow, pop && (count_q == '0), "request popped from an empty queue")

endmodule

### hdl/knnsel_back.sv
// back end: compare-and-shift slot array and rank-order emission
module knnsel_back (
	input  logic              clk,
	input  logic              arst_n,
	input  knnsel_pkg::cfg_t  cfg,
	input  logic              q_valid,
	input  knnsel_pkg::cand_t q_data,
	output logic              q_pop,
	knnsel_nbr_if.source      nbrs
);

	`include "knn_radius_topk_select_macros.svh"

	localparam int N = knnsel_pkg::MAX_NEIGHBORS;

	knnsel_pkg::back_state_t state_q, state_d;
	knnsel_pkg::slot_t slot_q [N];
	knnsel_pkg::slot_t base [N];
	knnsel_pkg::slot_t ins_val [N];
	knnsel_pkg::slot_t new_slot;
	logic [N-1:0] ahead, in_rng, a_ok, take;
	logic clear_pend_q;
	logic clr;
	logic emit_load;
	logic emit_done;
	logic [knnsel_pkg::RANK_BITS-1:0] emit_cnt_q, last_rank_q;

	logic out_valid_q;
	logic [knnsel_pkg::RANK_BITS-1:0] out_rank_q;
	logic signed [knnsel_pkg::OUT_INDEX_BITS-1:0] out_index_q;
	logic [knnsel_pkg::DIST_BITS-1:0] out_dist_q;
	logic out_last_q;

	// list starts over on a query start, after reset or after an emission
	assign clr = clear_pend_q | q_data.first;
	assign new_slot = '{sq_dist: q_data.sq_dist, idx: q_data.idx, valid: 1'b1};
	assign emit_done = emit_cnt_q == last_rank_q;

	// per-slot compare cells
	for (genvar i = 0; i < N; i++) begin : g_cell
		always_comb begin
			base[i] = clr ? knnsel_pkg::slot_t'{sq_dist: cfg.maxd, idx: '0, valid: 1'b0}
				: slot_q[i];
			ahead[i] = (q_data.sq_dist < base[i].sq_dist)
				|| ((q_data.sq_dist == base[i].sq_dist)
					&& (!base[i].valid || (q_data.idx < base[i].idx)));
			in_rng[i] = knnsel_pkg::CNT_BITS'(i) < cfg.k;
			a_ok[i] = ahead[i] | ~in_rng[i];
		end

		// slot moves when every active slot from here to the tail is beaten
		assign take[i] = in_rng[i] & (&a_ok[N-1:i]);

		if (i == 0) begin : g_head
			assign ins_val[i] = take[i] ? new_slot : base[i];
		end else begin : g_body
			assign ins_val[i] = take[i] ? (take[i-1] ? base[i-1] : new_slot) : base[i];
		end

		// insert, or shift towards the head while emitting
		if (i == N - 1) begin : g_tail
			always_ff @(posedge clk) begin
				if (q_pop)
					slot_q[i] <= ins_val[i];
			end
		end else begin : g_shift
			always_ff @(posedge clk) begin
				if (q_pop)
					slot_q[i] <= ins_val[i];
				else if (emit_load)
					slot_q[i] <= slot_q[i+1];
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= knnsel_pkg::BK_INSERT;
		else
			state_q <= state_d;
	end

	// next state and handshakes
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		emit_load = 1'b0;
		unique case (state_q)
			knnsel_pkg::BK_INSERT: begin
				q_pop = q_valid;
				if (q_valid && q_data.last)
					state_d = knnsel_pkg::BK_EMIT;
			end
			knnsel_pkg::BK_EMIT: begin
				emit_load = !out_valid_q || nbrs.ready;
				if (emit_load && emit_done)
					state_d = knnsel_pkg::BK_INSERT;
			end
		endcase
	end

	// emission counter and pending clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_pend_q <= 1'b1;
			emit_cnt_q   <= '0;
			last_rank_q  <= '0;
		end else begin
			if (q_pop) begin
				clear_pend_q <= 1'b0;
				emit_cnt_q   <= '0;
				last_rank_q  <= knnsel_pkg::RANK_BITS'(cfg.k - knnsel_pkg::CNT_BITS'(1));
			end else if (emit_load) begin
				emit_cnt_q <= emit_cnt_q + knnsel_pkg::RANK_BITS'(1);
				if (emit_done)
					clear_pend_q <= 1'b1;
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_load)
			out_valid_q <= 1'b1;
		else if (nbrs.ready)
			out_valid_q <= 1'b0;
	end

	// output register payload from the head slot
	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_rank_q  <= emit_cnt_q;
			out_index_q <= slot_q[0].valid
				? knnsel_pkg::OUT_INDEX_BITS'(slot_q[0].idx) : '1;
			out_dist_q  <= slot_q[0].sq_dist;
			out_last_q  <= emit_done;
		end
	end

	assign nbrs.valid                = out_valid_q;
	assign nbrs.neighbor_rank        = out_rank_q;
	assign nbrs.neighbor_index       = out_index_q;
	assign nbrs.neighbor_sq_distance = out_dist_q;
	assign nbrs.last_neighbor        = out_last_q;

	`KNN_ASSERT(a_last_starts_emit, (q_pop && q_data.last) |=> (state_q == knnsel_pkg::BK_EMIT) && (emit_cnt_q == '0), "last point did not start emission")
	`KNN_ASSERT(a_emit_end_clears, (emit_load && emit_done) |=> clear_pend_q && out_last_q && (state_q == knnsel_pkg::BK_INSERT), "emission end did not arm the list clear")

endmodule

### hdl/knn_radius_topk_select.sv
// top level: k nearest neighbours within a radius, selected from a candidate stream
// a point passes the three distance stages and the queue before it reaches the slot array
// throughput: one candidate per cycle unless stalled, via three-stage pipe and slot array
// emission: after the last point, k results from the output register, one per ready cycle
// reset: neighbour count 1, full radius, list cleared before the first candidate
module knn_radius_topk_select (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [knnsel_pkg::CFG_IDX_BITS-1:0]  wr_index,
	input  logic [knnsel_pkg::CFG_DATA_BITS-1:0] wr_data,
	knnsel_point_if.sink                         pts,
	knnsel_nbr_if.source                         nbrs
);

	logic [knnsel_pkg::NC_BITS-1:0] neighbor_count_q;
	logic [knnsel_pkg::DIST_BITS-1:0] max_sq_distance_q;
	knnsel_pkg::cfg_t cfg;

	logic push, pop, not_empty;
	knnsel_pkg::cand_t push_data, pop_data;
	logic [knnsel_pkg::QCNT_BITS-1:0] q_count;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			neighbor_count_q  <= knnsel_pkg::NEIGHBOR_COUNT_RESET;
			max_sq_distance_q <= knnsel_pkg::MAX_SQ_DISTANCE_RESET;
		end else if (wr_en) begin
			unique case (knnsel_pkg::cfg_reg_t'(wr_index))
				knnsel_pkg::CFG_NEIGHBOR_COUNT:
					neighbor_count_q <= wr_data[knnsel_pkg::NC_BITS-1:0];
				knnsel_pkg::CFG_MAX_SQ_DISTANCE:
					max_sq_distance_q <= wr_data[knnsel_pkg::DIST_BITS-1:0];
			endcase
		end
	end

	// neighbour count clamped to 1..MAX_NEIGHBORS
	always_comb begin
		cfg.maxd = max_sq_distance_q;
		if (neighbor_count_q == '0)
			cfg.k = knnsel_pkg::CNT_BITS'(1);
		else if (knnsel_pkg::KW_BITS'(neighbor_count_q)
				> knnsel_pkg::KW_BITS'(knnsel_pkg::MAX_NEIGHBORS))
			cfg.k = knnsel_pkg::CNT_BITS'(knnsel_pkg::MAX_NEIGHBORS);
		else
			cfg.k = knnsel_pkg::CNT_BITS'(neighbor_count_q);
	end

	knnsel_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pts       (pts),
		.q_count   (q_count),
		.push      (push),
		.push_data (push_data)
	);

	knnsel_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (not_empty),
		.count     (q_count)
	);

	knnsel_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.q_valid (not_empty),
		.q_data  (pop_data),
		.q_pop   (pop),
		.nbrs    (nbrs)
	);

endmodule

### tb/knn_radius_topk_select_tb.sv
// testbench for the knn radius top-k selector: directed and random queries against a local predictor
module knn_radius_topk_select_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// package constants used here
	localparam int COORD_BITS     = knnsel_pkg::COORD_BITS;
	localparam int INDEX_BITS     = knnsel_pkg::INDEX_BITS;
	localparam int DIST_BITS      = knnsel_pkg::DIST_BITS;
	localparam int OUT_INDEX_BITS = knnsel_pkg::OUT_INDEX_BITS;
	localparam int RANK_BITS      = knnsel_pkg::RANK_BITS;
	localparam int NC_BITS        = knnsel_pkg::NC_BITS;
	localparam int CFG_IDX_BITS   = knnsel_pkg::CFG_IDX_BITS;
	localparam int CFG_DATA_BITS  = knnsel_pkg::CFG_DATA_BITS;
	localparam int MAX_NEIGHBORS  = knnsel_pkg::MAX_NEIGHBORS;
	localparam logic [DIST_BITS-1:0] DIST_MAX = knnsel_pkg::DIST_MAX;
	localparam logic [NC_BITS-1:0] NEIGHBOR_COUNT_RESET = knnsel_pkg::NEIGHBOR_COUNT_RESET;
	localparam logic [DIST_BITS-1:0] MAX_SQ_DISTANCE_RESET = knnsel_pkg::MAX_SQ_DISTANCE_RESET;

	localparam int DRAIN_CYCLES = 16;
	localparam int PHASE_ITEMS  = 12;
	localparam int STALL_CYCLES = 300;

	// one candidate request as sent
	typedef struct {
		logic signed [COORD_BITS-1:0] qx, qy, qz;
		logic signed [COORD_BITS-1:0] px, py, pz;
		logic [INDEX_BITS-1:0]        idx;
		logic                         first;
		logic                         last;
	} point_t;

	// one neighbour request as expected on the output
	typedef struct {
		logic [RANK_BITS-1:0]             rank;
		logic signed [OUT_INDEX_BITS-1:0] index;
		logic [DIST_BITS-1:0]             sq_dist;
		logic                             last;
	} neighbor_t;

	logic                     clk;
	logic                     arst_n;
	logic                     wr_en;
	logic [CFG_IDX_BITS-1:0]  wr_index;
	logic [CFG_DATA_BITS-1:0] wr_data;

	knnsel_point_if pts();
	knnsel_nbr_if   nbrs();

	knn_radius_topk_select i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pts      (pts),
		.nbrs     (nbrs)
	);

	// predictor state: configuration and the sorted list
	logic [NC_BITS-1:0]    cfg_count  = NEIGHBOR_COUNT_RESET;
	logic [DIST_BITS-1:0]  cfg_radius = MAX_SQ_DISTANCE_RESET;
	logic [DIST_BITS-1:0]  top_dist [MAX_NEIGHBORS];
	logic [INDEX_BITS-1:0] top_idx  [MAX_NEIGHBORS];
	bit                    top_used [MAX_NEIGHBORS];
	bit                    list_stale = 1'b1;

	neighbor_t expected_nbrs [$];

	int  errors          = 0;
	int  items_sent      = 0;
	int  queries_done    = 0;
	int  results_checked = 0;
	bit  src_idle        = 1'b1;
	bit  snk_idle        = 1'b1;
	int  hold_left       = 0;

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// effective neighbour count after clamping
	function automatic int kept_count();
		if (cfg_count == 0)
			return 1;
		if (cfg_count > MAX_NEIGHBORS)
			return MAX_NEIGHBORS;
		return int'(cfg_count);
	endfunction

	// exact squared 3-d distance, always fits 42 bits for 20-bit coordinates
	function automatic logic [DIST_BITS-1:0] sq_distance(input point_t p);
		longint dx, dy, dz;
		dx = longint'(p.qx) - longint'(p.px);
		dy = longint'(p.qy) - longint'(p.py);
		dz = longint'(p.qz) - longint'(p.pz);
		return DIST_BITS'(dx * dx + dy * dy + dz * dz);
	endfunction

	// candidate beats the slot: nearer, or same distance with lower index or empty slot
	function automatic bit ranks_before(input logic [DIST_BITS-1:0] d,
			input logic [INDEX_BITS-1:0] idx, input int slot);
		if (d < top_dist[slot])
			return 1'b1;
		if (d == top_dist[slot])
			return !top_used[slot] || idx < top_idx[slot];
		return 1'b0;
	endfunction

	// insert one accepted candidate and queue the neighbours it releases
	function automatic void predict_candidate(input point_t p);
		int k;
		int r;
		logic [DIST_BITS-1:0] d;
		neighbor_t n;
		k = kept_count();
		if (p.first || list_stale) begin
			for (int i = 0; i < MAX_NEIGHBORS; i++) begin
				top_dist[i] = cfg_radius;
				top_idx[i]  = '0;
				top_used[i] = 1'b0;
			end
			list_stale = 1'b0;
		end
		d = sq_distance(p);
		if (ranks_before(d, p.idx, k - 1)) begin
			r = k - 1;
			while (r > 0 && ranks_before(d, p.idx, r - 1)) begin
				top_dist[r] = top_dist[r-1];
				top_idx[r]  = top_idx[r-1];
				top_used[r] = top_used[r-1];
				r--;
			end
			top_dist[r] = d;
			top_idx[r]  = p.idx;
			top_used[r] = 1'b1;
		end
		if (p.last) begin
			for (int i = 0; i < k; i++) begin
				n.rank    = RANK_BITS'(i);
				n.index   = top_used[i] ? OUT_INDEX_BITS'(top_idx[i]) : {OUT_INDEX_BITS{1'b1}};
				n.sq_dist = top_dist[i];
				n.last    = (i == k - 1);
				expected_nbrs.push_back(n);
			end
			list_stale = 1'b1;
			queries_done++;
		end
	endfunction

	function automatic point_t mk_point(input int qx, input int qy, input int qz,
			input int px, input int py, input int pz, input int unsigned idx,
			input bit first, input bit last);
		point_t p;
		p.qx    = COORD_BITS'(qx);
		p.qy    = COORD_BITS'(qy);
		p.qz    = COORD_BITS'(qz);
		p.px    = COORD_BITS'(px);
		p.py    = COORD_BITS'(py);
		p.pz    = COORD_BITS'(pz);
		p.idx   = INDEX_BITS'(idx);
		p.first = first;
		p.last  = last;
		return p;
	endfunction

	// offer one candidate request and wait for it to be taken
	task automatic send_point(input point_t p);
		if (src_idle && $urandom_range(99) < 11) begin
			pts.valid <= 1'b0;
			@(posedge clk);
		end
		pts.valid       <= 1'b1;
		pts.query_x     <= p.qx;
		pts.query_y     <= p.qy;
		pts.query_z     <= p.qz;
		pts.point_x     <= p.px;
		pts.point_y     <= p.py;
		pts.point_z     <= p.pz;
		pts.point_index <= p.idx;
		pts.first_point <= p.first;
		pts.last_point  <= p.last;
		@(posedge clk);
		while (!pts.ready)
			@(posedge clk);
		predict_candidate(p);
		items_sent++;
	endtask

	// stop offering and let every expected neighbour arrive
	task automatic wait_drained();
		pts.valid <= 1'b0;
		while (expected_nbrs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// write both registers back to back
	task automatic write_config(input logic [DIST_BITS-1:0] count_word,
			input logic [DIST_BITS-1:0] radius);
		wr_en    <= 1'b1;
		wr_index <= knnsel_pkg::CFG_NEIGHBOR_COUNT;
		wr_data  <= count_word;
		@(posedge clk);
		wr_index <= knnsel_pkg::CFG_MAX_SQ_DISTANCE;
		wr_data  <= radius;
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_count  = count_word[NC_BITS-1:0];
		cfg_radius = radius;
	endtask

	// full-scale coordinates at reset settings, first item with no query start flag
	task automatic test_coordinate_extremes();
		send_point(mk_point(-524288, -524288, -524288, 524287, 524287, 524287,
			24'hFFFFFF, 1'b0, 1'b1));
		send_point(mk_point(524287, 524287, 524287, -524288, -524288, -524288,
			0, 1'b1, 1'b1));
		send_point(mk_point(-1, 0, 1, -1, 0, 1, 24'h5A5A5A, 1'b1, 1'b1));
		wait_drained();
	endtask

	// points exactly on the radius are kept, one beyond is not
	task automatic test_radius_boundary();
		write_config(3, 25);
		send_point(mk_point(0, 0, 0, 3, 4, 0, 10, 1'b1, 1'b0));
		send_point(mk_point(0, 0, 0, 0, 5, 0, 4, 1'b0, 1'b0));
		send_point(mk_point(0, 0, 0, 1, 0, 5, 2, 1'b0, 1'b0));
		send_point(mk_point(0, 0, 0, 0, 0, 0, 7, 1'b0, 1'b1));
		wait_drained();
	endtask

	// equal distances sort by index, equal index does not displace
	task automatic test_equal_rank();
		send_point(mk_point(0, 0, 0, 1, 0, 0, 9, 1'b1, 1'b0));
		send_point(mk_point(0, 0, 0, 0, 1, 0, 9, 1'b0, 1'b0));
		send_point(mk_point(0, 0, 0, 0, 0, 1, 2, 1'b0, 1'b0));
		send_point(mk_point(0, 0, 0, -1, 0, 0, 9, 1'b0, 1'b1));
		wait_drained();
	endtask

	// count zero acts as one, above the maximum acts as the maximum, zero radius
	task automatic test_count_limits();
		write_config(0, 0);
		send_point(mk_point(7, 7, 7, 7, 7, 7, 3, 1'b1, 1'b1));
		send_point(mk_point(0, 0, 0, 1, 0, 0, 5, 1'b1, 1'b0));
		send_point(mk_point(0, 0, 0, 0, 0, 0, 6, 1'b0, 1'b1));
		wait_drained();
		write_config(127, DIST_MAX);
		send_point(mk_point(100, -100, 50, 90, -90, 40, 11, 1'b1, 1'b0));
		send_point(mk_point(100, -100, 50, 100, -100, 50, 12, 1'b0, 1'b1));
		wait_drained();
	endtask

	// list clears after an emission and again on a mid-query start flag
	task automatic test_implicit_start();
		write_config(4, MAX_SQ_DISTANCE_RESET);
		send_point(mk_point(0, 0, 0, 2, 0, 0, 1, 1'b0, 1'b0));
		send_point(mk_point(0, 0, 0, 0, 3, 0, 2, 1'b0, 1'b0));
		send_point(mk_point(0, 0, 0, 0, 0, 1, 3, 1'b1, 1'b0));
		send_point(mk_point(0, 0, 0, 1, 1, 0, 4, 1'b0, 1'b1));
		wait_drained();
	endtask

	// one query of random shape and content
	task automatic send_random_query(inout int sent);
		int mode, len;
		bit tidy;
		point_t p;
		mode = $urandom_range(0, 3);
		len  = $urandom_range(1, 8);
		tidy = $urandom_range(9) < 8;
		p.qx = COORD_BITS'($urandom);
		p.qy = COORD_BITS'($urandom);
		p.qz = COORD_BITS'($urandom);
		for (int i = 0; i < len; i++) begin
			case (mode)
				0: begin
					p.px = COORD_BITS'($urandom);
					p.py = COORD_BITS'($urandom);
					p.pz = COORD_BITS'($urandom);
				end
				2: begin
					p.px = COORD_BITS'(int'(p.qx) + int'($urandom_range(0, 2)) - 1);
					p.py = COORD_BITS'(int'(p.qy) + int'($urandom_range(0, 2)) - 1);
					p.pz = COORD_BITS'(int'(p.qz) + int'($urandom_range(0, 2)) - 1);
				end
				default: begin
					p.px = COORD_BITS'(int'(p.qx) + int'($urandom_range(0, 32)) - 16);
					p.py = COORD_BITS'(int'(p.qy) + int'($urandom_range(0, 32)) - 16);
					p.pz = COORD_BITS'(int'(p.qz) + int'($urandom_range(0, 32)) - 16);
				end
			endcase
			p.idx = (mode == 2) ? INDEX_BITS'($urandom_range(0, 7)) : INDEX_BITS'($urandom);
			if (tidy) begin
				p.first = (i == 0);
				p.last  = (i == len - 1);
			end else begin
				p.first = ($urandom_range(3) == 0);
				p.last  = ($urandom_range(3) == 0);
			end
			send_point(p);
			sent++;
		end
	endtask

	// random settings per phase, first phase without any idling
	task automatic test_random_queries();
		logic [DIST_BITS-1:0] count_word;
		logic [DIST_BITS-1:0] radius;
		int sent;
		for (int phase = 0; phase < 4; phase++) begin
			src_idle   = (phase != 0);
			snk_idle   = (phase != 0);
			count_word = DIST_BITS'({$urandom, $urandom});
			case ($urandom_range(0, 5))
				0: count_word[NC_BITS-1:0] = NC_BITS'(0);
				1: count_word[NC_BITS-1:0] = NC_BITS'(1);
				2: count_word[NC_BITS-1:0] = NC_BITS'(MAX_NEIGHBORS);
				3: count_word[NC_BITS-1:0] = NC_BITS'($urandom_range(65, 127));
				default: count_word[NC_BITS-1:0] = NC_BITS'($urandom_range(2, 63));
			endcase
			case ($urandom_range(0, 4))
				0: radius = MAX_SQ_DISTANCE_RESET;
				1: radius = DIST_MAX;
				2: radius = DIST_BITS'($urandom_range(0, 64));
				3: radius = DIST_BITS'($urandom_range(0, 4000));
				default: radius = DIST_BITS'({$urandom, $urandom});
			endcase
			write_config(count_word, radius);
			sent = 0;
			while (sent < PHASE_ITEMS)
				send_random_query(sent);
			// close any open query so the block ends the phase idle
			send_point(mk_point(0, 0, 0, 0, 0, 0, $urandom, 1'b0, 1'b1));
			wait_drained();
		end
		src_idle = 1'b1;
		snk_idle = 1'b1;
	endtask

	// output held off while full-size queries keep arriving until the input stalls
	task automatic test_output_stall();
		int sent;
		write_config(DIST_BITS'(MAX_NEIGHBORS), DIST_MAX);
		src_idle  = 1'b0;
		hold_left = STALL_CYCLES;
		sent = 0;
		for (int q = 0; q < 12; q++)
			send_point(mk_point(q, -q, 3 * q, q + 1, -q, 3 * q - 1, q, 1'b1, 1'b1));
		src_idle = 1'b1;
		wait_drained();
		send_random_query(sent);
		wait_drained();
	endtask

	// output ready with random idling and an occasional long hold-off
	initial begin
		nbrs.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				nbrs.ready <= 1'b0;
				hold_left--;
			end else begin
				nbrs.ready <= !(snk_idle && $urandom_range(99) < 11);
			end
		end
	end

	// compare every neighbour request with the oldest expectation
	task automatic check_field(input string name, input logic signed [63:0] exp_v,
			input logic signed [63:0] act_v);
		if (exp_v !== act_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk) begin : nbr_check
		neighbor_t e;
		if (arst_n && nbrs.valid && nbrs.ready) begin
			results_checked++;
			if (expected_nbrs.size() == 0) begin
				errors++;
				$display("%0t: unexpected neighbour, expected none, actual rank %0d index %0d dist %0d",
					$time, nbrs.neighbor_rank, nbrs.neighbor_index, nbrs.neighbor_sq_distance);
			end else begin
				e = expected_nbrs.pop_front();
				check_field("neighbor_rank", e.rank, nbrs.neighbor_rank);
				check_field("neighbor_index", e.index, nbrs.neighbor_index);
				check_field("neighbor_sq_distance", e.sq_dist, nbrs.neighbor_sq_distance);
				check_field("last_neighbor", e.last, nbrs.last_neighbor);
			end
		end
	end

	// run limit
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// reset, tests in turn, verdict
	initial begin
		arst_n          <= 1'b0;
		wr_en           <= 1'b0;
		wr_index        <= knnsel_pkg::CFG_NEIGHBOR_COUNT;
		wr_data         <= '0;
		pts.valid       <= 1'b0;
		pts.query_x     <= '0;
		pts.query_y     <= '0;
		pts.query_z     <= '0;
		pts.point_x     <= '0;
		pts.point_y     <= '0;
		pts.point_z     <= '0;
		pts.point_index <= '0;
		pts.first_point <= 1'b0;
		pts.last_point  <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_coordinate_extremes();
		test_radius_boundary();
		test_equal_rank();
		test_count_limits();
		test_implicit_start();
		test_random_queries();
		test_output_stall();
		wait_drained();

		$display("covered %0d candidates in %0d queries, %0d neighbours checked",
			items_sent, queries_done, results_checked);
		$display("counts 0 to 127, radii 0 to full scale, ties, implicit starts, output stalls");
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/knnsel_pkg.sv
hdl/knnsel_ifs.sv
hdl/knnsel_front.sv
hdl/knnsel_fifo.sv
hdl/knnsel_back.sv
hdl/knn_radius_topk_select.sv
tb/knn_radius_topk_select_tb.sv
